### rtl/tvhr_pkg.sv
// Shared constants and control/status types of the typed value hash reducer.
`default_nettype none
package tvhr_pkg;

  localparam int HASH_WIDTH_DEF = 32;
  localparam int MAX_ROUNDS_DEF = 64;

  localparam int FIELD_WIDTH = 32;
  localparam int KIND_WIDTH  = 3;

  localparam logic [FIELD_WIDTH-1:0] LIMIT_RESET = 32'd1024;

  localparam logic [KIND_WIDTH-1:0] KIND_UNSIGNED = 3'd0;
  localparam logic [KIND_WIDTH-1:0] KIND_SIGNED   = 3'd1;
  localparam logic [KIND_WIDTH-1:0] KIND_CHAR     = 3'd2;
  localparam logic [KIND_WIDTH-1:0] KIND_STRING   = 3'd3;
  localparam logic [KIND_WIDTH-1:0] KIND_BOOL     = 3'd4;
  localparam logic [KIND_WIDTH-1:0] KIND_EMPTY    = 3'd5;

  localparam int EXPAND_MUL  = 3;
  localparam int EXPAND_ADD  = 13;
  localparam int BOOL_TRUE   = 127;
  localparam int BOOL_FALSE  = 2389;

  typedef struct packed {
    logic load;
    logic expand;
    logic mod_step;
    logic out_load;
    logic out_err;
  } tvhr_cmd_t;

  typedef struct packed {
    logic no_result;
    logic skip_expand;
    logic lim_zero;
    logic below;
    logic rounds_max;
    logic mod_last;
  } tvhr_sts_t;

endpackage
`default_nettype wire

### rtl/tvhr_dp.sv
// Datapath: limit register, string sum, start value, expansion and restoring modulo.
`default_nettype none
module tvhr_dp #(
  parameter int HASH_WIDTH = tvhr_pkg::HASH_WIDTH_DEF,
  parameter int MAX_ROUNDS = tvhr_pkg::MAX_ROUNDS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  input  wire logic [tvhr_pkg::FIELD_WIDTH-1:0]    hash_limit,
  input  wire logic [tvhr_pkg::KIND_WIDTH-1:0]     kind,
  input  wire logic [tvhr_pkg::FIELD_WIDTH-1:0]    value,
  input  wire logic                                last,
  input  wire tvhr_pkg::tvhr_cmd_t                 cmd,
  output tvhr_pkg::tvhr_sts_t                      sts,
  output logic [tvhr_pkg::FIELD_WIDTH-1:0]         hash,
  output logic                                     error
);

  localparam int W  = HASH_WIDTH;
  localparam int FW = tvhr_pkg::FIELD_WIDTH;
  localparam int RW = $clog2(MAX_ROUNDS + 1);
  localparam int CW = $clog2(W);

  logic [FW-1:0]   limit;
  logic [W-1:0]    string_sum;
  logic [W-1:0]    v;
  logic [W-1:0]    rem;
  logic            sgn;
  logic [RW-1:0]   rounds;
  logic [CW-1:0]   count;

  logic [W+FW-1:0] lim_wide;
  logic [W-1:0]    lim;
  logic [W+FW-1:0] val_zext;
  logic [W+FW-1:0] val_sext;
  logic [W+7:0]    chr_wide;
  logic [W-1:0]    chr;
  logic [W-1:0]    sum_next;
  logic [W-1:0]    sval;
  logic [W-1:0]    start;
  logic [W:0]      shifted;
  logic [W:0]      diff;
  logic [W+FW-1:0] rem_wide;

  assign lim_wide = {{W{1'b0}}, limit};
  assign lim      = lim_wide[W-1:0];
  assign val_zext = {{W{1'b0}}, value};
  assign val_sext = {{W{value[FW-1]}}, value};
  assign chr_wide = {{W{value[7]}}, value[7:0]};
  assign chr      = chr_wide[W-1:0];
  assign sum_next = string_sum + chr;

  // Negative signed operands are scaled by -2.
  always_comb begin
    sval = val_sext[W-1:0];
    if (sval[W-1]) begin
      sval = '0 - {sval[W-2:0], 1'b0};
    end
  end

  always_comb begin
    case (kind)
      tvhr_pkg::KIND_UNSIGNED: start = val_zext[W-1:0];
      tvhr_pkg::KIND_SIGNED:   start = sval;
      tvhr_pkg::KIND_CHAR:     start = chr;
      tvhr_pkg::KIND_STRING:   start = sum_next;
      tvhr_pkg::KIND_BOOL:     start = value[0] ? W'(tvhr_pkg::BOOL_TRUE)
                                                : W'(tvhr_pkg::BOOL_FALSE);
      default:                 start = '0;
    endcase
  end

  assign shifted = {rem, v[W-1]};
  assign diff    = shifted - {1'b0, lim};

  always_comb begin
    sts.no_result   = (kind > tvhr_pkg::KIND_EMPTY) ||
                      ((kind == tvhr_pkg::KIND_STRING) && !last);
    sts.skip_expand = (kind == tvhr_pkg::KIND_BOOL);
    sts.lim_zero    = (lim == '0);
    sts.below       = sgn ? ($signed(v) < $signed(lim)) : (v < lim);
    sts.rounds_max  = (rounds == RW'(MAX_ROUNDS));
    sts.mod_last    = (count == CW'(W - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit      <= tvhr_pkg::LIMIT_RESET;
      string_sum <= '0;
    end else begin
      if (cfg_valid) begin
        limit <= hash_limit;
      end
      if (cmd.load) begin
        if (kind == tvhr_pkg::KIND_STRING) begin
          string_sum <= last ? '0 : sum_next;
        end else if (kind == tvhr_pkg::KIND_EMPTY) begin
          string_sum <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v      <= start;
      sgn    <= (kind == tvhr_pkg::KIND_SIGNED);
      rounds <= '0;
      rem    <= '0;
      count  <= '0;
    end else if (cmd.expand) begin
      v      <= v + {v[W-2:0], 1'b0} + W'(tvhr_pkg::EXPAND_ADD);
      rounds <= rounds + 1'b1;
    end else if (cmd.mod_step) begin
      // one restoring step: shift in the next bit, subtract when it fits
      v     <= {v[W-2:0], 1'b0};
      rem   <= diff[W] ? shifted[W-1:0] : diff[W-1:0];
      count <= count + 1'b1;
    end
  end

  assign rem_wide = {{FW{1'b0}}, rem};

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      hash  <= cmd.out_err ? '0 : rem_wide[FW-1:0];
      error <= cmd.out_err;
    end
  end

endmodule
`default_nettype wire

### rtl/tvhr_ctrl.sv
// Controller: sequences load, expansion rounds, modulo steps and the result handoff.
`default_nettype none
module tvhr_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire tvhr_pkg::tvhr_sts_t  sts,
  output tvhr_pkg::tvhr_cmd_t       cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXPAND = 2'd1;
  localparam logic [1:0] S_MOD    = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       err;
  logic       err_next;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next   = state;
    err_next     = err;
    cmd          = '0;
    cmd.out_err  = err;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          err_next = 1'b0;
          if (sts.no_result) begin
            state_next = S_IDLE;
          end else if (sts.lim_zero) begin
            err_next   = 1'b1;
            state_next = S_FINISH;
          end else if (sts.skip_expand) begin
            state_next = S_MOD;
          end else begin
            state_next = S_EXPAND;
          end
        end
      end
      S_EXPAND: begin
        if (!sts.below) begin
          state_next = S_MOD;
        end else if (sts.rounds_max) begin
          err_next   = 1'b1;
          state_next = S_FINISH;
        end else begin
          cmd.expand = 1'b1;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        // hold until the output register is free
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      err       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      err   <= err_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/typed_value_hash_reducer.sv
// Top level of the typed value hash reducer: controller plus datapath.
//
// Hashes one typed word (unsigned, signed, char, string char, bool, empty
// string) into 0 to hash_limit-1. An item is accepted, then runs up to
// MAX_ROUNDS rounds of the 3v+13 expansion (one round per cycle on the
// HASH_WIDTH-bit adder), then restoring modulo over the HASH_WIDTH bits (one
// quotient bit per cycle), then loads the output register once it is free.
// Bool skips the expansion. A zero limit goes from the accept straight to
// the finish state and loads error with hash 0; running out of rounds goes
// from the last round to the finish state and loads it the same way. String
// chars without last, and kinds 6 and 7, are taken and give no result. The
// next item is accepted while a finished result still waits in the output
// register. The user must write hash_limit only while the block is idle;
// the block itself does not enforce it. cfg_ready is always high.
`default_nettype none
module typed_value_hash_reducer #(
  parameter int HASH_WIDTH = tvhr_pkg::HASH_WIDTH_DEF,
  parameter int MAX_ROUNDS = tvhr_pkg::MAX_ROUNDS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [tvhr_pkg::FIELD_WIDTH-1:0]  hash_limit,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [tvhr_pkg::KIND_WIDTH-1:0]   kind,
  input  wire logic [tvhr_pkg::FIELD_WIDTH-1:0]  value,
  input  wire logic                              last,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [tvhr_pkg::FIELD_WIDTH-1:0]       hash,
  output logic                                   error
);

  tvhr_pkg::tvhr_cmd_t cmd;
  tvhr_pkg::tvhr_sts_t sts;

  assign cfg_ready = 1'b1;

  tvhr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tvhr_dp #(
    .HASH_WIDTH (HASH_WIDTH),
    .MAX_ROUNDS (MAX_ROUNDS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .hash_limit (hash_limit),
    .kind       (kind),
    .value      (value),
    .last       (last),
    .cmd        (cmd),
    .sts        (sts),
    .hash       (hash),
    .error      (error)
  );

endmodule
`default_nettype wire

### sim/tb_typed_value_hash_reducer.sv
// Self-checking testbench of the typed value hash reducer: random traffic, own hash predictor.
`default_nettype none
module tb_typed_value_hash_reducer;
  timeunit 1ns;
  timeprecision 1ps;

  import tvhr_pkg::*;

  localparam int HW            = HASH_WIDTH_DEF;
  localparam int ROUND_LIMIT   = MAX_ROUNDS_DEF;
  localparam int SETTLE_CYCLES = ROUND_LIMIT + HW + 8;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_WORDS  = 1950;
  localparam int PHASES        = 9;
  localparam int RX_HOLD_CYCLES = 400;

  // Kinds outside the defined set: taken, no result, no state change.
  localparam logic [KIND_WIDTH-1:0] KIND_RSVD6 = 3'd6;
  localparam logic [KIND_WIDTH-1:0] KIND_RSVD7 = 3'd7;

  typedef struct {
    logic [KIND_WIDTH-1:0]  kind;
    logic [FIELD_WIDTH-1:0] value;
    logic                   last;
  } hash_word_in_t;

  typedef struct packed {
    logic [FIELD_WIDTH-1:0] hash;
    logic                   error;
  } hash_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [FIELD_WIDTH-1:0] cfg_limit = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [KIND_WIDTH-1:0]  kind = '0;
  logic [FIELD_WIDTH-1:0] value = '0;
  logic                   last = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [FIELD_WIDTH-1:0] out_hash;
  logic                   out_error;

  typed_value_hash_reducer dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .hash_limit (cfg_limit),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .value      (value),
    .last       (last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hash       (out_hash),
    .error      (out_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  hash_word_in_t word_pending[$];
  hash_result_t  hash_expected[$];

  logic [HW-1:0] limit_now = HW'(LIMIT_RESET);
  logic [HW-1:0] string_total = '0;

  int words_queued   = 0;
  int words_accepted = 0;
  int hashed_words   = 0;
  int mismatches     = 0;
  int cycle_count    = 0;

  logic in_taken  = 1'b0;
  logic out_taken = 1'b0;
  logic tx_steady = 1'b0;
  logic rx_steady = 1'b0;
  logic rx_hold_req = 1'b0;
  int   rx_hold_left = 0;
  int   tx_gap = 0;
  int   rx_wait = 0;
  hash_word_in_t tx_word;

  // ---------------------------------------------------------------- predictor

  function automatic logic is_below(input logic [HW-1:0] v, input logic signed_cmp);
    if (signed_cmp)
      return $signed(v) < $signed(limit_now);
    return v < limit_now;
  endfunction

  function automatic logic [HW-1:0] sext_byte(input logic [7:0] b);
    return HW'($signed(b));
  endfunction

  // Expand by 3v+13 while below the limit, then reduce mod the limit.
  function automatic hash_result_t reduce_start(input logic [HW-1:0] start,
                                                input logic signed_cmp);
    hash_result_t res;
    logic [HW-1:0] v;
    int r;
    res = '0;
    v = start;
    if (limit_now == '0) begin
      res.error = 1'b1;
      return res;
    end
    for (r = 0; r < ROUND_LIMIT && is_below(v, signed_cmp); r++)
      v = v * EXPAND_MUL + EXPAND_ADD;
    if (is_below(v, signed_cmp))
      res.error = 1'b1;
    else
      res.hash = FIELD_WIDTH'(v % limit_now);
    return res;
  endfunction

  function automatic logic predict_hash(input hash_word_in_t w, output hash_result_t res);
    logic [HW-1:0] start;
    res = '0;
    case (w.kind)
      KIND_UNSIGNED: res = reduce_start(HW'(w.value), 1'b0);
      KIND_SIGNED: begin
        start = HW'($signed(w.value));
        if (start[HW-1])
          start = -(start << 1);
        res = reduce_start(start, 1'b1);
      end
      KIND_CHAR: res = reduce_start(sext_byte(w.value[7:0]), 1'b0);
      KIND_STRING: begin
        string_total = string_total + sext_byte(w.value[7:0]);
        if (!w.last)
          return 1'b0;
        res = reduce_start(string_total, 1'b0);
        string_total = '0;
      end
      KIND_BOOL: begin
        if (limit_now == '0)
          res.error = 1'b1;
        else
          res.hash = FIELD_WIDTH'((w.value[0] ? HW'(BOOL_TRUE) : HW'(BOOL_FALSE)) % limit_now);
      end
      KIND_EMPTY: begin
        string_total = '0;
        res = reduce_start('0, 1'b0);
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    hash_result_t  hash_want;
    hash_word_in_t taken_word;
    if (rst) begin
      in_taken  <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (hash_expected.size() == 0) begin
          report_mismatch($sformatf("result with none pending: hash %h error %b",
                                    out_hash, out_error));
        end else begin
          hash_want = hash_expected.pop_front();
          if (out_hash !== hash_want.hash)
            report_mismatch($sformatf("hash %h, wanted %h", out_hash, hash_want.hash));
          if (out_error !== hash_want.error)
            report_mismatch($sformatf("error %b, wanted %b", out_error, hash_want.error));
        end
      end
      if (in_valid && in_ready) begin
        taken_word.kind  = kind;
        taken_word.value = value;
        taken_word.last  = last;
        if (predict_hash(taken_word, hash_want))
          hash_expected.push_back(hash_want);
        words_accepted++;
      end
      in_taken  <= in_valid && in_ready;
      out_taken <= out_valid && out_ready;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- driver

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (tx_gap != 0) begin
        in_valid <= 1'b0;
        tx_gap--;
      end else if (word_pending.size() != 0) begin
        tx_word = word_pending.pop_front();
        kind     <= tx_word.kind;
        value    <= tx_word.value;
        last     <= tx_word.last;
        in_valid <= 1'b1;
        tx_gap = tx_steady ? 0 : $urandom_range(0, 5);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver stall, counted apart from the per-word stalls.
  always @(posedge clk) begin
    if (rst)
      rx_hold_left <= 0;
    else if (rx_hold_req)
      rx_hold_left <= RX_HOLD_CYCLES;
    else if (rx_hold_left != 0)
      rx_hold_left <= rx_hold_left - 1;
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_taken)
        rx_wait = rx_steady ? 0 : $urandom_range(0, 5);
      if (rx_hold_left != 0) begin
        out_ready <= 1'b0;
      end else if (rx_wait != 0) begin
        out_ready <= 1'b0;
        rx_wait--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic void queue_word(input logic [KIND_WIDTH-1:0] k,
                                     input logic [FIELD_WIDTH-1:0] v, input logic l);
    hash_word_in_t w;
    w.kind  = k;
    w.value = v;
    w.last  = l;
    word_pending.push_back(w);
    words_queued++;
    if (k != KIND_RSVD6 && k != KIND_RSVD7)
      hashed_words++;
  endfunction

  function automatic logic [FIELD_WIDTH-1:0] random_value();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40)
      return $urandom;
    if (pick < 60)
      return $urandom_range(0, 300);
    if (pick < 72)
      return 32'hFFFF_FFFF - $urandom_range(0, 300);
    if (pick < 84)
      return 32'h8000_0000 + $urandom_range(0, 300) - 150;
    // land close to the limit on either side
    return FIELD_WIDTH'(limit_now) + $urandom_range(0, 40) - 20;
  endfunction

  function automatic logic [KIND_WIDTH-1:0] scalar_kind();
    case ($urandom_range(0, 3))
      0:       return KIND_UNSIGNED;
      1:       return KIND_SIGNED;
      2:       return KIND_CHAR;
      default: return KIND_BOOL;
    endcase
  endfunction

  task automatic queue_random_words(input int target);
    int stop;
    int pick;
    int n;
    int i;
    stop = hashed_words + target;
    while (hashed_words < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++) begin
          if (i != 0 && $urandom_range(0, 7) == 0)
            queue_word(scalar_kind(), random_value(), 1'($urandom_range(0, 1)));
          queue_word(KIND_STRING, random_value(), i == n - 1);
        end
      end else if (pick < 35) begin
        queue_word(KIND_EMPTY, random_value(), 1'($urandom_range(0, 1)));
      end else if (pick < 39) begin
        // abandon a string; the empty string drops its partial sum
        n = $urandom_range(1, 3);
        for (i = 0; i < n; i++)
          queue_word(KIND_STRING, random_value(), 1'b0);
        queue_word(KIND_EMPTY, random_value(), 1'($urandom_range(0, 1)));
      end else if (pick < 42) begin
        queue_word(pick[0] ? KIND_RSVD6 : KIND_RSVD7, $urandom,
                   1'($urandom_range(0, 1)));
      end else begin
        queue_word(scalar_kind(), random_value(), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    while (words_accepted != words_queued || hash_expected.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [FIELD_WIDTH-1:0] lim);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_limit <= lim;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    limit_now = HW'(lim);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [FIELD_WIDTH-1:0] phase_limits [PHASES];
    int p;
    phase_limits = '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'd37, 32'd0, 32'd0, 32'd0};
    phase_limits[6] = $urandom_range(2, 4096);
    phase_limits[7] = $urandom;
    phase_limits[8] = $urandom_range(1000, 100000);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed words at the reset limit
    queue_word(KIND_UNSIGNED, 32'h0000_0000, 1'b0);
    queue_word(KIND_UNSIGNED, 32'hFFFF_FFFF, 1'b1);
    queue_word(KIND_UNSIGNED, 32'd1023, 1'b0);
    queue_word(KIND_UNSIGNED, 32'd1024, 1'b0);
    queue_word(KIND_SIGNED, 32'h8000_0000, 1'b0);
    queue_word(KIND_SIGNED, 32'hFFFF_FFFF, 1'b0);
    queue_word(KIND_SIGNED, 32'h7FFF_FFFF, 1'b1);
    queue_word(KIND_SIGNED, 32'h0000_0000, 1'b0);
    queue_word(KIND_CHAR, 32'h0000_007F, 1'b0);
    queue_word(KIND_CHAR, 32'hFFFF_FF80, 1'b0);
    queue_word(KIND_CHAR, 32'h1234_5600, 1'b0);
    queue_word(KIND_STRING, 32'h0000_0061, 1'b0);
    queue_word(KIND_STRING, 32'h0000_0062, 1'b1);
    queue_word(KIND_STRING, 32'h0000_00FF, 1'b1);
    // other kinds in the middle of a string keep its sum
    queue_word(KIND_STRING, 32'h0000_0078, 1'b0);
    queue_word(KIND_UNSIGNED, 32'd5, 1'b0);
    queue_word(KIND_BOOL, 32'h0000_0001, 1'b0);
    queue_word(KIND_STRING, 32'h0000_0079, 1'b1);
    queue_word(KIND_EMPTY, 32'h0000_0000, 1'b0);
    queue_word(KIND_STRING, 32'h0000_0041, 1'b0);
    queue_word(KIND_EMPTY, 32'hFFFF_FFFF, 1'b1);
    queue_word(KIND_BOOL, 32'hFFFF_FFFE, 1'b1);
    queue_word(KIND_RSVD6, 32'hA5A5_A5A5, 1'b1);
    queue_word(KIND_RSVD7, 32'h5A5A_5A5A, 1'b0);
    drain_results();

    for (p = 0; p < PHASES; p++) begin
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      write_limit(phase_limits[p]);
      queue_random_words(RANDOM_WORDS / PHASES + 1);
      if (p == 4) begin
        // stall the output long enough to back up the input
        @(negedge clk) rx_hold_req <= 1'b1;
        @(negedge clk) rx_hold_req <= 1'b0;
      end
      drain_results();
    end

    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
`default_nettype wire

### filelist.f
rtl/tvhr_pkg.sv
rtl/tvhr_dp.sv
rtl/tvhr_ctrl.sv
rtl/typed_value_hash_reducer.sv
sim/tb_typed_value_hash_reducer.sv
